// ===== sv/key_debounce_short_long_press_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef KEY_DEBOUNCE_SHORT_LONG_PRESS_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_SHORT_LONG_PRESS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define KDSLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define KDSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked across reset.
`define KDSLP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/kdslp_pkg.sv =====
`default_nettype none

package kdslp_pkg;

   // Width of timestamps and time thresholds
   localparam int TIME_BITS = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LEVEL    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS_TIME = 2'd2;

   // Reset values of the configuration registers
   localparam logic [TIME_BITS-1:0] DEBOUNCE_TIME_RESET   = TIME_BITS'(20);
   localparam logic [TIME_BITS-1:0] LONG_PRESS_TIME_RESET = TIME_BITS'(1000);

   typedef struct packed {
      logic                 pin_level;
      logic [TIME_BITS-1:0] now_ms;
      logic                 consume_short;
      logic                 consume_long;
   } req_type;

   typedef struct packed {
      logic pressed;
      logic short_press;
      logic long_press;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/key_debounce_short_long_press_unit.sv =====
// Debounced push button with short and long press detection.
// req channel: one pin sample per transfer (raw level, ms timestamp, consume
//    flags). A transfer happens on a rising edge with req_valid high and
//    req_stall low.
// rsp channel: one result per sample (stable state, short and long pending
//    flags), same transfer rule with rsp_valid and rsp_stall.
// csr channel: register writes (0 active level, 1 debounce time, 2 long press
//    time) with csr_valid and csr_ready; csr_ready is always high. Write only
//    while no sample is in flight.
// A req transfer lands in the input register; the debounce and hold update is
// then computed in one pass and lands in the result register, which drives
// rsp_valid. Throughput is one sample per cycle unless the result is stalled.
// The state update is combinational compare-and-update logic, so each
// sample sees the state left by the one before it.
// A stalled result holds the result register; the input register still fills
// behind it, and req_stall rises only when both registers are occupied.
// Synchronous reset empties both registers, restores the register defaults
// and puts the button in the released state at time 0.
`default_nettype none

module key_debounce_short_long_press_unit
   import kdslp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_type                   req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      rsp_type                   rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [TIME_BITS-1:0]      csr_data
);

   // Configuration registers
   logic                 active_level_ff, active_level_in;
   logic [TIME_BITS-1:0] debounce_time_ff, debounce_time_in;
   logic [TIME_BITS-1:0] long_press_time_ff, long_press_time_in;

   // Pipeline registers
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   // Button state
   logic                 raw_pressed_ff, raw_pressed_in;
   logic                 stable_pressed_ff, stable_pressed_in;
   logic [TIME_BITS-1:0] last_change_ff, last_change_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic                 long_fired_ff, long_fired_in;
   logic                 short_pending_ff, short_pending_in;
   logic                 long_pending_ff, long_pending_in;

   // Update terms
   logic                 advance;
   logic                 req_xfer;
   logic                 sample;
   logic                 raw_change;
   logic [TIME_BITS-1:0] since_change;
   logic [TIME_BITS-1:0] since_press;
   logic                 debounce_done;
   logic                 go_stable;
   logic                 new_press;
   logic                 fired_mid;
   logic                 short_mid;
   logic                 hold_done;
   logic                 fire_long;

   // Handshakes
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      active_level_in    = active_level_ff;
      debounce_time_in   = debounce_time_ff;
      long_press_time_in = long_press_time_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACTIVE_LEVEL:    active_level_in    = csr_data[0];
            CSR_DEBOUNCE_TIME:   debounce_time_in   = csr_data;
            CSR_LONG_PRESS_TIME: long_press_time_in = csr_data;
            default: ;
         endcase
      end
   end

   // Debounce and hold update for the sample in the input register
   always_comb begin
      sample        = (in_data_ff.pin_level == active_level_ff);
      raw_change    = (sample != raw_pressed_ff);
      since_change  = in_data_ff.now_ms - last_change_ff;
      since_press   = in_data_ff.now_ms - press_start_ff;
      // a fresh raw change has zero elapsed time
      debounce_done = raw_change ? (debounce_time_ff == '0)
                                 : (since_change >= debounce_time_ff);
      go_stable     = (sample != stable_pressed_ff) && debounce_done;
      new_press     = go_stable && sample;
      fired_mid     = new_press ? 1'b0 : long_fired_ff;
      short_mid     = short_pending_ff || (go_stable && !sample && !long_fired_ff);
      hold_done     = new_press ? (long_press_time_ff == '0)
                                : (since_press >= long_press_time_ff);
      stable_pressed_in = go_stable ? sample : stable_pressed_ff;
      fire_long     = stable_pressed_in && !fired_mid && hold_done;

      raw_pressed_in   = raw_pressed_ff;
      last_change_in   = last_change_ff;
      press_start_in   = press_start_ff;
      long_fired_in    = long_fired_ff;
      short_pending_in = short_pending_ff;
      long_pending_in  = long_pending_ff;
      if (advance) begin
         raw_pressed_in   = sample;
         last_change_in   = raw_change ? in_data_ff.now_ms : last_change_ff;
         press_start_in   = new_press ? in_data_ff.now_ms : press_start_ff;
         long_fired_in    = fired_mid || fire_long;
         short_pending_in = short_mid && !in_data_ff.consume_short;
         long_pending_in  = (long_pending_ff || fire_long) && !in_data_ff.consume_long;
      end else begin
         stable_pressed_in = stable_pressed_ff;
      end
   end

   // Pipeline next values
   always_comb begin
      in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_data_in   = req_xfer ? req_data : in_data_ff;
      out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);
      out_data_in  = out_data_ff;
      if (advance) begin
         out_data_in.pressed     = stable_pressed_in;
         out_data_in.short_press = short_mid;
         out_data_in.long_press  = long_pending_ff || fire_long;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff    <= 1'b0;
         debounce_time_ff   <= DEBOUNCE_TIME_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         raw_pressed_ff     <= 1'b0;
         stable_pressed_ff  <= 1'b0;
         last_change_ff     <= '0;
         press_start_ff     <= '0;
         long_fired_ff      <= 1'b0;
         short_pending_ff   <= 1'b0;
         long_pending_ff    <= 1'b0;
      end else begin
         active_level_ff    <= active_level_in;
         debounce_time_ff   <= debounce_time_in;
         long_press_time_ff <= long_press_time_in;
         in_valid_ff        <= in_valid_in;
         out_valid_ff       <= out_valid_in;
         raw_pressed_ff     <= raw_pressed_in;
         stable_pressed_ff  <= stable_pressed_in;
         last_change_ff     <= last_change_in;
         press_start_ff     <= press_start_in;
         long_fired_ff      <= long_fired_in;
         short_pending_ff   <= short_pending_in;
         long_pending_ff    <= long_pending_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule

`default_nettype wire

// ===== sv/kdslp_checker.sv =====
`default_nettype none
`include "key_debounce_short_long_press_unit_defines.svh"

module kdslp_checker
   import kdslp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result stays offered and unchanged
   `KDSLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "rsp changed while stalled")

   // Reset empties the result register
   `KDSLP_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "rsp_valid after reset")

   // Every accepted sample is followed by a result offer, behind the input and result registers
   `KDSLP_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall,
      ##1 rsp_valid, "no result after sample transfer")

endmodule

bind key_debounce_short_long_press_unit kdslp_checker u_kdslp_checker (.*);

`default_nettype wire

// ===== bench/key_debounce_short_long_press_unit_tb.sv =====
`timescale 1ns / 1ps

module key_debounce_short_long_press_unit_tb
   import kdslp_pkg::*;
();

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int DUT_LATENCY = 2;
   localparam int STALL_LIMIT = 4000;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ACTIVE_LEVEL;
   logic [TIME_BITS-1:0]      csr_data = '0;

   key_debounce_short_long_press_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Button model: configuration and state as seen by the block
   logic                 cfg_active   = 1'b0;
   logic [TIME_BITS-1:0] cfg_debounce = DEBOUNCE_TIME_RESET;
   logic [TIME_BITS-1:0] cfg_long     = LONG_PRESS_TIME_RESET;
   logic                 btn_raw      = 1'b0;
   logic                 btn_stable   = 1'b0;
   logic [TIME_BITS-1:0] t_change     = '0;
   logic [TIME_BITS-1:0] t_press      = '0;
   logic                 long_done    = 1'b0;
   logic                 short_flag   = 1'b0;
   logic                 long_flag    = 1'b0;

   rsp_type              button_due[$];
   int                   errors      = 0;
   int                   items_sent  = 0;
   int                   send_gap_pct = 0;
   int                   rsp_hold_pct = 0;
   int                   idle_cycles = 0;
   logic [TIME_BITS-1:0] t_now       = '0;

   // Debounce, hold timer and pending flags for one pin sample
   function automatic rsp_type predict_button(input req_type s);
      rsp_type r;
      logic    hit;
      hit = (s.pin_level == cfg_active);
      if (hit != btn_raw) begin
         btn_raw  = hit;
         t_change = s.now_ms;
      end
      // differences wrap at the timestamp width
      if (btn_raw != btn_stable && TIME_BITS'(s.now_ms - t_change) >= cfg_debounce) begin
         btn_stable = btn_raw;
         if (btn_stable) begin
            t_press   = s.now_ms;
            long_done = 1'b0;
         end else if (!long_done) begin
            short_flag = 1'b1;
         end
      end
      if (btn_stable && !long_done && TIME_BITS'(s.now_ms - t_press) >= cfg_long) begin
         long_done = 1'b1;
         long_flag = 1'b1;
      end
      r.pressed     = btn_stable;
      r.short_press = short_flag;
      r.long_press  = long_flag;
      // consume clears only after the flag has been reported
      if (s.consume_short) short_flag = 1'b0;
      if (s.consume_long) long_flag = 1'b0;
      return r;
   endfunction

   // One sample transfer; valid is left high for a back-to-back follow-up
   task automatic send_sample(input logic pin, input logic [TIME_BITS-1:0] stamp,
                              input logic c_short, input logic c_long);
      req_type item;
      item.pin_level     = pin;
      item.now_ms        = stamp;
      item.consume_short = c_short;
      item.consume_long  = c_long;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      button_due.push_back(predict_button(item));
      items_sent++;
   endtask

   // Advance the running timestamp and send with random consume flags
   task automatic press_step(input logic pin, input logic [TIME_BITS-1:0] dt);
      t_now = t_now + dt;
      send_sample(pin, t_now, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 30);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (button_due.size() != 0) @(posedge clock);
   endtask

   // Register writes, only once the block has nothing in flight
   task automatic apply_config(input logic act, input logic [TIME_BITS-1:0] deb,
                               input logic [TIME_BITS-1:0] lng, input logic poke_unused);
      logic [CSR_INDEX_BITS-1:0] idx_list[4];
      logic [TIME_BITS-1:0]      val_list[4];
      int                        n_regs;
      idx_list = '{CSR_ACTIVE_LEVEL, CSR_DEBOUNCE_TIME, CSR_LONG_PRESS_TIME, CSR_UNUSED};
      val_list = '{{{(TIME_BITS-1){1'b0}}, act}, deb, lng, $urandom()};
      n_regs   = poke_unused ? 4 : 3;
      wait_results_drained();
      for (int k = 0; k < n_regs; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[k];
         csr_data  <= val_list[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx_list[k])
            CSR_ACTIVE_LEVEL:    cfg_active   = val_list[k][0];
            CSR_DEBOUNCE_TIME:   cfg_debounce = val_list[k];
            CSR_LONG_PRESS_TIME: cfg_long     = val_list[k];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Reset values: active low pin, bounce, long press, release after long
   task automatic test_default_levels();
      send_sample(1'b1, 32'd0, 1'b0, 1'b0);
      send_sample(1'b0, 32'd5, 1'b0, 1'b0);
      send_sample(1'b0, 32'd24, 1'b0, 1'b0);
      send_sample(1'b0, 32'd25, 1'b0, 1'b0);
      send_sample(1'b0, 32'd1024, 1'b0, 1'b0);
      send_sample(1'b0, 32'd1025, 1'b0, 1'b0);
      send_sample(1'b0, 32'd1030, 1'b0, 1'b1);
      send_sample(1'b1, 32'd1040, 1'b0, 1'b0);
      send_sample(1'b1, 32'd1060, 1'b1, 1'b1);
   endtask

   // Zero debounce: press and release stable at once, short press flagged
   task automatic test_short_press();
      apply_config(1'b1, '0, TIME_MAX, 1'b1);
      send_sample(1'b1, 32'd100, 1'b0, 1'b0);
      send_sample(1'b0, 32'd101, 1'b0, 1'b0);
      send_sample(1'b0, 32'd102, 1'b1, 1'b0);
      send_sample(1'b0, 32'd103, 1'b0, 1'b0);
   endtask

   // Zero long press time fires in the step of the stable press
   task automatic test_zero_long();
      apply_config(1'b1, '0, '0, 1'b0);
      send_sample(1'b1, 32'd200, 1'b0, 1'b1);
      send_sample(1'b0, 32'd201, 1'b0, 1'b0);
   endtask

   // Full-scale thresholds reached only through timestamp wrap
   task automatic test_wrap_limits();
      apply_config(1'b0, TIME_MAX, TIME_MAX, 1'b0);
      send_sample(1'b0, TIME_MAX, 1'b0, 1'b0);
      send_sample(1'b0, 32'h0000_0000, 1'b0, 1'b0);
      send_sample(1'b0, 32'hFFFF_FFFE, 1'b0, 1'b0);
      send_sample(1'b0, 32'hFFFF_FFFD, 1'b1, 1'b1);
      send_sample(1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1);
   endtask

   // Random configuration, then mostly bouncy press/release cycles plus noise
   task automatic test_random_presses(input int n_items);
      logic                 act;
      logic [TIME_BITS-1:0] deb;
      logic [TIME_BITS-1:0] lng;
      logic                 lvl;
      int                   base;
      int                   deb_span;
      int                   long_span;
      act = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0:       deb = '0;
         1:       deb = TIME_MAX;
         default: deb = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 5))
         0:       lng = '0;
         1:       lng = TIME_MAX;
         2:       lng = $urandom();
         default: lng = $urandom_range(5, 80);
      endcase
      apply_config(act, deb, lng, $urandom_range(0, 3) == 0);
      deb_span  = (cfg_debounce > 40) ? 40 : int'(cfg_debounce);
      long_span = (cfg_long > 100) ? 100 : int'(cfg_long);
      base      = items_sent;
      while (items_sent - base < n_items) begin
         if ($urandom_range(0, 99) < 78) begin
            // press with contact bounce, hold, release with bounce
            lvl = ~cfg_active;
            repeat ($urandom_range(0, 4)) begin
               lvl = ~lvl;
               press_step(lvl, $urandom_range(0, deb_span));
            end
            press_step(cfg_active, $urandom_range(0, deb_span));
            press_step(cfg_active, cfg_debounce + $urandom_range(0, 1));
            repeat ($urandom_range(1, 5)) press_step(cfg_active, $urandom_range(0, long_span / 2 + 1));
            if ($urandom_range(0, 1)) press_step(cfg_active, cfg_long);
            lvl = cfg_active;
            repeat ($urandom_range(0, 4)) begin
               lvl = ~lvl;
               press_step(lvl, $urandom_range(0, deb_span));
            end
            press_step(~cfg_active, $urandom_range(0, deb_span));
            press_step(~cfg_active, cfg_debounce + $urandom_range(0, 1));
            repeat ($urandom_range(0, 2)) press_step(~cfg_active, $urandom_range(0, deb_span + 5));
         end else begin
            // noise: arbitrary levels, jumps and time running backwards
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1)) t_now = $urandom();
               else t_now = t_now - $urandom_range(0, 50);
               press_step(1'($urandom_range(0, 1)), '0);
            end
         end
      end
   endtask

   // Result checking against the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (button_due.size() == 0) begin
            $error("result transfer with no prediction pending");
            errors++;
         end else begin
            want = button_due.pop_front();
            if (rsp_data.pressed !== want.pressed) begin
               $error("pressed: expected %0b, got %0b", want.pressed, rsp_data.pressed);
               errors++;
            end
            if (rsp_data.short_press !== want.short_press) begin
               $error("short_press: expected %0b, got %0b", want.short_press,
                      rsp_data.short_press);
               errors++;
            end
            if (rsp_data.long_press !== want.long_press) begin
               $error("long_press: expected %0b, got %0b", want.long_press,
                      rsp_data.long_press);
               errors++;
            end
         end
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_hold_pct);
   end

   // Watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 29;
      rsp_hold_pct = 64;
      test_default_levels();
      test_short_press();
      test_zero_long();
      test_wrap_limits();
      repeat (3) test_random_presses(150);

      send_gap_pct = 64;
      rsp_hold_pct = 29;
      repeat (3) test_random_presses(150);

      send_gap_pct = 0;
      rsp_hold_pct = 0;
      repeat (3) test_random_presses(150);

      wait_results_drained();
      repeat (DUT_LATENCY * 4) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/kdslp_pkg.sv
sv/key_debounce_short_long_press_unit.sv
sv/kdslp_checker.sv
bench/key_debounce_short_long_press_unit_tb.sv
